### hw/rtl/tilt_pkg.sv
// Shared types, constants and tables of the accelerometer tilt unit.
package tilt_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int TABLE_LEN           = 24;
	localparam int ANG_FRAC            = 30;
	localparam int SQRT_STEPS          = 24;   // one root bit per stage, 24 root bits
	localparam int RAD_W               = 48;   // radicand is at most 2^47
	localparam int ROOT_W              = 24;
	localparam int CX_W                = 28;   // CORDIC x/y width, gain 1.65 on 24 bits
	localparam int ANG_W               = 33;   // radians, 30 fraction bits, signed
	localparam longint DEG_NUM         = 1800000;
	localparam longint DEG_DEN         = 31416;

	typedef struct packed {
		logic [7:0] x_low;
		logic [7:0] x_high;
		logic [7:0] y_low;
		logic [7:0] y_high;
		logic [7:0] z_low;
		logic [7:0] z_high;
	} tilt_in_t;

	typedef struct packed {
		logic signed [15:0] tilt_x;
		logic signed [15:0] tilt_y;
	} tilt_out_t;

	function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
		logic signed [ANG_W-1:0] v;
		case (i)
			0:  v = 33'sd843314857;
			1:  v = 33'sd497837830;
			2:  v = 33'sd263043837;
			3:  v = 33'sd133525159;
			4:  v = 33'sd67021687;
			5:  v = 33'sd33543516;
			6:  v = 33'sd16775851;
			7:  v = 33'sd8388438;
			8:  v = 33'sd4194283;
			9:  v = 33'sd2097149;
			default: v = ANG_W'(64'sd1 << (30 - i));
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/accel_tilt_angles_unit.sv
// Top level of the accelerometer tilt unit: square root, CORDIC and degree stages.
//
// One input transaction carries a raw sample (six bytes, low and high per
// axis); one output transaction carries tilt_x and tilt_y in degrees, signed,
// ANGLE_FRAC_BITS fraction bits, saturated to 16 bits.
// Both angles are computed side by side in two identical lanes. Each lane has
// a square stage, a radicand stage, a restoring square root with one result
// bit per stage, a vectoring CORDIC with one rotation per stage, and four
// degree stages: magnitude, multiply by a precomputed reciprocal, a one-step
// correction of the rounded quotient, and sign with saturation.
// Throughput is one transaction per cycle while out_stall is low.
// A stage holds only when it is full and the stage after it holds, so empty
// stages keep filling while the output is stalled; in_stall rises once every
// stage is full and out_stall is high.
// Reset clears all valid bits; no data register is reset.
module accel_tilt_angles_unit
	import tilt_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tilt_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output tilt_out_t out_data
);

	localparam int NS   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int NST  = 3 + SQRT_STEPS + 1 + NS + 4;
	localparam int SH   = ANG_FRAC - ANGLE_FRAC_BITS;
	// DEG_NUM over the scaled denominator, rounded up, 40 fraction bits
	localparam longint DEN = DEG_DEN << SH;
	localparam int RB    = 40;
	localparam longint RECIP = ((DEG_NUM << RB) + DEN - 1) / DEN;
	localparam int RECW  = 40;

	// stage valid bits and advance enables
	logic [NST-1:0] v_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !v_q[NST-1] || !out_stall;
		for (int k = NST - 2; k >= 0; k--)
			adv[k] = !v_q[k] || adv[k+1];
	end
	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					v_q[k] <= v_q[k-1];
		end
	end

	// lane 0: tilt_x = atan2(y, |x,z|); lane 1: -atan2(x, |y,z|)
	logic signed [15:0] sx, sy, sz;
	assign sx = $signed({in_data.x_high, in_data.x_low});
	assign sy = $signed({in_data.y_high, in_data.y_low});
	assign sz = $signed({in_data.z_high, in_data.z_low});

	// stage 0: capture operands
	logic signed [15:0] a_s0 [2];
	logic signed [15:0] b_s0 [2];
	logic signed [15:0] c_s0 [2];
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			a_s0[0] <= sy; b_s0[0] <= sx; c_s0[0] <= sz;
			a_s0[1] <= sx; b_s0[1] <= sy; c_s0[1] <= sz;
		end
	end

	// stage 1: squares
	logic [31:0] bb_s1 [2];
	logic [31:0] cc_s1 [2];
	logic signed [15:0] a_s1 [2];
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int l = 0; l < 2; l++) begin
				bb_s1[l] <= 32'(b_s0[l]) * 32'(b_s0[l]);
				cc_s1[l] <= 32'(c_s0[l]) * 32'(c_s0[l]);
				a_s1[l]  <= a_s0[l];
			end
		end
	end

	// stage 2: radicand (b^2 + c^2) * 2^16
	logic [RAD_W-1:0] rad_s2 [2];
	logic signed [15:0] a_s2 [2];
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int l = 0; l < 2; l++) begin
				rad_s2[l] <= RAD_W'({1'b0, bb_s1[l]} + {1'b0, cc_s1[l]}) << 16;
				a_s2[l]   <= a_s1[l];
			end
		end
	end

	// square root: stages 3 .. 3+SQRT_STEPS-1, two radicand bits per stage
	logic [RAD_W-1:0]  rem_p [2][SQRT_STEPS+1];
	logic [ROOT_W-1:0] rt_p  [2][SQRT_STEPS+1];
	logic [RAD_W-1:0]  rr_p  [2][SQRT_STEPS+1];
	logic signed [15:0] aq_p [2][SQRT_STEPS+1];

	for (genvar l = 0; l < 2; l++) begin : g_sq
		assign rem_p[l][0] = '0;
		assign rt_p[l][0]  = '0;
		assign rr_p[l][0]  = rad_s2[l];
		assign aq_p[l][0]  = a_s2[l];
		for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_st
			logic [RAD_W-1:0]  rem_n;
			logic [RAD_W-1:0]  trial;
			logic [RAD_W-1:0]  rem_s;
			logic [ROOT_W-1:0] rt_s;
			logic [RAD_W-1:0]  rr_s;
			logic signed [15:0] a_s;
			always_comb begin
				rem_n = {rem_p[l][j][RAD_W-3:0], rr_p[l][j][RAD_W-1 -: 2]};
				trial = RAD_W'({rt_p[l][j], 2'b01});
			end
			always_ff @(posedge clk) begin
				if (adv[3+j]) begin
					if (rem_n >= trial) begin
						rem_s <= rem_n - trial;
						rt_s  <= {rt_p[l][j][ROOT_W-2:0], 1'b1};
					end else begin
						rem_s <= rem_n;
						rt_s  <= {rt_p[l][j][ROOT_W-2:0], 1'b0};
					end
					rr_s <= rr_p[l][j] << 2;
					a_s  <= aq_p[l][j];
				end
			end
			assign rem_p[l][j+1] = rem_s;
			assign rt_p[l][j+1]  = rt_s;
			assign rr_p[l][j+1]  = rr_s;
			assign aq_p[l][j+1]  = a_s;
		end
	end

	logic [ROOT_W-1:0] root_f [2];
	logic signed [15:0] a_f [2];
	for (genvar l = 0; l < 2; l++) begin : g_fin
		assign root_f[l] = rt_p[l][SQRT_STEPS];
		assign a_f[l]    = aq_p[l][SQRT_STEPS];
	end

	// CORDIC stage inputs registered after the last root bit
	localparam int C0 = 3 + SQRT_STEPS;
	logic signed [CX_W-1:0]  cx [2][NS+1];
	logic signed [CX_W-1:0]  cy [2][NS+1];
	logic signed [ANG_W-1:0] cz [2][NS+1];
	logic                    cnz [2][NS+1];

	for (genvar l = 0; l < 2; l++) begin : g_cor
		logic signed [CX_W-1:0] x0_s, y0_s;
		logic nz0_s;
		always_ff @(posedge clk) begin
			if (adv[C0]) begin
				x0_s  <= CX_W'($signed({1'b0, root_f[l]}));
				y0_s  <= CX_W'($signed({a_f[l], 8'd0}));
				nz0_s <= (a_f[l] != 16'sd0);
			end
		end
		assign cx[l][0]  = x0_s;
		assign cy[l][0]  = y0_s;
		assign cz[l][0]  = '0;
		assign cnz[l][0] = nz0_s;
		for (genvar i = 0; i < NS; i++) begin : g_it
			logic signed [CX_W-1:0]  xs, ys;
			logic signed [ANG_W-1:0] zs;
			logic                    nzs;
			always_ff @(posedge clk) begin
				if (adv[C0+1+i]) begin
					if (!cy[l][i][CX_W-1]) begin
						xs <= cx[l][i] + (cy[l][i] >>> i);
						ys <= cy[l][i] - (cx[l][i] >>> i);
						zs <= cz[l][i] + atan_tab(i);
					end else begin
						xs <= cx[l][i] - (cy[l][i] >>> i);
						ys <= cy[l][i] + (cx[l][i] >>> i);
						zs <= cz[l][i] - atan_tab(i);
					end
					nzs <= cnz[l][i];
				end
			end
			assign cx[l][i+1]  = xs;
			assign cy[l][i+1]  = ys;
			assign cz[l][i+1]  = zs;
			assign cnz[l][i+1] = nzs;
		end
	end

	// degree scaling: q = round(|z| * DEG_NUM / DEN), reciprocal estimate and one correction
	localparam int D0 = C0 + 1 + NS;
	localparam int MW = ANG_W + RECW;
	localparam int LW = 64;
	localparam int QW = 32;
	localparam longint DEN2 = DEN * 2;
	logic [ANG_W-1:0] mag_s1 [2];
	logic             neg_s1 [2];
	logic [MW-1:0]    prod_s2 [2];
	logic [LW-1:0]    lhs_s2 [2];
	logic             neg_s2 [2];
	logic [QW-1:0]    q_est [2];
	logic [QW-1:0]    q_inc [2];
	logic [QW-1:0]    q_s3 [2];
	logic             neg_s3 [2];
	tilt_out_t        res_s4;

	function automatic logic signed [15:0] sat_angle(input logic [QW-1:0] q, input logic ng);
		if (!ng && q > QW'(32767))
			return 16'sh7fff;
		if (ng && q > QW'(32768))
			return 16'sh8000;
		return ng ? 16'(-q) : 16'(q);
	endfunction

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			q_est[l] = QW'(prod_s2[l] >> RB);
			q_inc[l] = q_est[l] + QW'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (adv[D0]) begin
				mag_s1[l] <= !cnz[l][NS] ? '0 :
					(cz[l][NS][ANG_W-1] ? ANG_W'(-cz[l][NS]) : ANG_W'(cz[l][NS]));
				neg_s1[l] <= cnz[l][NS] && cz[l][NS][ANG_W-1];
			end
			if (adv[D0+1]) begin
				// (2|z| + 1) * RECIP / 2 is never below the rounded quotient, as RECIP is rounded up.
				prod_s2[l] <= (MW'({mag_s1[l], 1'b1}) * MW'(RECIP)) >> 1;
				lhs_s2[l]  <= LW'(mag_s1[l]) * LW'(2 * DEG_NUM) + LW'(DEN);
				neg_s2[l]  <= neg_s1[l];
			end
			if (adv[D0+2]) begin
				q_s3[l]   <= (lhs_s2[l] >= LW'(q_inc[l]) * LW'(DEN2)) ? q_inc[l] : q_est[l];
				neg_s3[l] <= neg_s2[l];
			end
		end
		if (adv[D0+3]) begin
			res_s4.tilt_x <= sat_angle(q_s3[0], neg_s3[0]);
			res_s4.tilt_y <= sat_angle(q_s3[1], !neg_s3[1]);
		end
	end

	assign out_valid = v_q[NST-1];
	assign out_data  = res_s4;

endmodule

### hw/rtl/tilt_checker.sv
// Port-level checker of the accelerometer tilt unit, bound to the top level.
module tilt_port_checks
	import tilt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input tilt_out_t out_data
);

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The input side blocks only while a result waits.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// With the output free, the input is never stalled.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	// Handshake outputs are always known once out of reset.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown");

endmodule

bind accel_tilt_angles_unit tilt_port_checks u_tilt_port_checks (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### verif/tilt_checker.sv
// Checker for the tilt unit: predicts each sample's angles and compares the results.
module tilt_checker
	import tilt_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  tilt_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  tilt_out_t out_data,
	output int        mismatches,
	output int        pending,
	output int        results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	tilt_out_t angle_fifo[$];

	function automatic longint sample_word(logic [7:0] lo, logic [7:0] hi);
		logic signed [15:0] w;
		w = {hi, lo};
		return longint'(w);
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n    = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint atan_entry(int i);
		longint t[10] = '{843314857, 497837830, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388438, 4194283, 2097149};
		if (i < 10)
			return t[i];
		return longint'(64'd1 << (30 - i));
	endfunction

	// Angle of a against the length of (b, c), in degrees with fraction bits.
	function automatic longint tilt_deg(longint a, longint b, longint c);
		longint xr, yr, zacc, dx, dy;
		longint unsigned mag, num, den, q;
		int steps;
		xr = longint'(int_root(longint'(b * b + c * c) << 16));
		yr = a * 256;
		zacc = 0;
		steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
		if (a == 0)
			return 0;
		for (int i = 0; i < steps; i++) begin
			dx = yr >>> i;
			dy = xr >>> i;
			if (yr >= 0) begin
				xr += dx;
				yr -= dy;
				zacc += atan_entry(i);
			end else begin
				xr -= dx;
				yr += dy;
				zacc -= atan_entry(i);
			end
		end
		mag = (zacc < 0) ? -zacc : zacc;
		num = mag * 64'd1800000;
		den = 64'd31416 << (ANG_FRAC - ANGLE_FRAC_BITS);
		q = (num + den / 2) / den;
		return (zacc < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] sat16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic tilt_out_t predict_angles(tilt_in_t s);
		longint x, y, z;
		tilt_out_t r;
		x = sample_word(s.x_low, s.x_high);
		y = sample_word(s.y_low, s.y_high);
		z = sample_word(s.z_low, s.z_high);
		r.tilt_x = sat16(tilt_deg(y, x, z));
		r.tilt_y = sat16(-tilt_deg(x, y, z));
		return r;
	endfunction

	initial begin
		mismatches = 0;
		results_seen = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		tilt_out_t exp_r;
		if (arst_n) begin
			if (in_valid && !in_stall)
				angle_fifo.push_back(predict_angles(in_data));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (angle_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: tilt_x=%0d tilt_y=%0d",
							out_data.tilt_x, out_data.tilt_y);
				end else begin
					exp_r = angle_fifo.pop_front();
					if (exp_r.tilt_x !== out_data.tilt_x || exp_r.tilt_y !== out_data.tilt_y) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: tilt_x exp %0d got %0d, tilt_y exp %0d got %0d",
								exp_r.tilt_x, out_data.tilt_x, exp_r.tilt_y, out_data.tilt_y);
					end
				end
			end
		end
		pending = angle_fifo.size();
	end
endmodule

### verif/tb_accel_tilt_angles_unit.sv
// Testbench top of the tilt unit: stimulus, receiver stalls, watchdog and verdict.
module tb_accel_tilt_angles_unit;
	import tilt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1280;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	tilt_in_t  in_data;
	logic      out_valid;
	logic      out_stall;
	tilt_out_t out_data;
	int        mismatches, pending, results_seen;
	int        idle_cycles;
	int        samples_sent;
	bit        hold_req;
	bit        hold_done;

	accel_tilt_angles_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	tilt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall pattern changes mode every so often, plus one long hold-off.
	initial begin
		int mode;
		out_stall = 1'b0;
		hold_done = 0;
		forever begin
			if (hold_req && !hold_done) begin
				repeat (HOLD_CYCLES) @(posedge clk) out_stall <= 1'b1;
				hold_done = 1;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(8, 80)) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic tilt_in_t pack_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		tilt_in_t s;
		s = '{x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
		return s;
	endfunction

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 40));
			1: return 16'hFFFF - 16'($urandom_range(0, 40));
			2: return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF;
			3: return 16'd0;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offers one sample and holds it until the block takes it.
	task automatic send_sample(tilt_in_t s);
		bit took;
		in_valid <= 1'b1;
		in_data  <= s;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		samples_sent++;
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		logic [15:0] d[12] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
			16'h4000, 16'hC000, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0100};
		in_valid = 1'b0;
		in_data  = '0;
		hold_req = 0;
		idle_cycles = 0;
		samples_sent = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all zero, single axes (zero denominator), extremes, mixed bytes.
		send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000));
		send_sample(pack_sample(16'h7FFF, 16'h0000, 16'h0000));
		send_sample(pack_sample(16'h8000, 16'h0000, 16'h0000));
		send_sample(pack_sample(16'h0000, 16'h7FFF, 16'h0000));
		send_sample(pack_sample(16'h0000, 16'h8000, 16'h0000));
		send_sample(pack_sample(16'h0000, 16'h0000, 16'h8000));
		send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000));
		send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_sample(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h0000));
		for (int i = 0; i < 12; i++)
			send_sample(pack_sample(d[i], d[(i + 5) % 12], d[(i + 9) % 12]));
		idle_gap(1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300) begin
				// Sender keeps offering while the receiver holds off.
				hold_req = 1;
				while (!hold_done) send_sample(pack_sample(rand_axis(), rand_axis(), rand_axis()));
			end
			if (i == 700) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_sample(pack_sample(rand_axis(), rand_axis(), rand_axis()));
			if ($urandom_range(0, 15) == 0)
				idle_gap($urandom_range(1, 20));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d samples with %0d results: zero, single-axis and extreme axes,",
			samples_sent, results_seen);
		$display("random bursts, long output hold-off and a drain pause");
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
